[rtl/core/fipt_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the fuel injector pulse timer.
// No dependencies; every other file of the block imports this package.
package fipt_pkg;

  localparam int unsigned DefaultTableDepth = 128;

  // Widths fixed by the item and register formats.
  localparam int unsigned OpW      = 3;
  localparam int unsigned SampleW  = 8;
  localparam int unsigned IndexW   = 7;
  localparam int unsigned EntryW   = 8;
  localparam int unsigned TimeW    = 10;
  localparam int unsigned TachW    = 16;
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;

  // Register reset values.
  localparam logic [IndexW-1:0] ThrottleMinRst    = 7'd0;
  localparam logic [IndexW-1:0] ThrottleMaxRst    = 7'd119;
  localparam logic [EntryW-1:0] InjectorOffsetRst = 8'd1;
  localparam logic [EntryW-1:0] CorrectionSpanRst = 8'd30;
  localparam logic [TachW-1:0]  StallLimitRst     = 16'd20000;

  typedef enum logic [OpW-1:0] {
    OpTick       = 3'd0,
    OpCrank      = 3'd1,
    OpThrottle   = 3'd2,
    OpCorrection = 3'd3,
    OpTableWrite = 3'd4
  } fipt_op_e;

  typedef enum logic [2:0] {
    RegThrottleMin    = 3'd0,
    RegThrottleMax    = 3'd1,
    RegInjectorOffset = 3'd2,
    RegCorrectionSpan = 3'd3,
    RegStallLimit     = 3'd4
  } fipt_reg_e;

  typedef struct packed {
    logic [IndexW-1:0] throttle_min;
    logic [IndexW-1:0] throttle_max;
    logic [EntryW-1:0] injector_offset;
    logic [EntryW-1:0] correction_span;
    logic [TachW-1:0]  stall_limit;
  } fipt_cfg_t;

endpackage

[rtl/core/fipt_in_if.sv]
`timescale 1ns / 1ps
// Input channel of the fuel injector pulse timer: valid/ready plus one event.
// Depends on fipt_pkg for the field widths.
interface fipt_in_if
  import fipt_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OpW-1:0]      op;
  logic [SampleW-1:0]  sample;
  logic [IndexW-1:0]   entry_index;
  logic [EntryW-1:0]   entry_value;

  modport source (output valid, op, sample, entry_index, entry_value, input ready);
  modport sink   (input valid, op, sample, entry_index, entry_value, output ready);
endinterface

[rtl/core/fipt_out_if.sv]
`timescale 1ns / 1ps
// Result channel of the fuel injector pulse timer: valid/ready plus one status beat.
// Depends on fipt_pkg for the field widths.
interface fipt_out_if
  import fipt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              injector_open;
  logic              late_flow_fault;
  logic [TachW-1:0]  period_ticks;
  logic [TimeW-1:0]  time_left;
  logic [IndexW-1:0] index_now;
  logic              low_speed;

  modport source (output valid, injector_open, late_flow_fault, period_ticks, time_left,
                  index_now, low_speed, input ready);
  modport sink   (input valid, injector_open, late_flow_fault, period_ticks, time_left,
                  index_now, low_speed, output ready);
endinterface

[rtl/core/fipt_cfg_regs.sv]
`timescale 1ns / 1ps
// APB register file of the fuel injector pulse timer (five registers at 4*i).
// Depends on fipt_pkg for the register map and the configuration struct.
module fipt_cfg_regs
  import fipt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output fipt_cfg_t           cfg_o
);

  fipt_cfg_t cfg_q, cfg_d;
  fipt_reg_e sel;
  logic      wr_en;

  assign sel    = fipt_reg_e'(paddr[ApbAddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        RegThrottleMin:    cfg_d.throttle_min    = pwdata[IndexW-1:0];
        RegThrottleMax:    cfg_d.throttle_max    = pwdata[IndexW-1:0];
        RegInjectorOffset: cfg_d.injector_offset = pwdata[EntryW-1:0];
        RegCorrectionSpan: cfg_d.correction_span = pwdata[EntryW-1:0];
        RegStallLimit:     cfg_d.stall_limit     = pwdata[TachW-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      RegThrottleMin:    prdata = ApbDataW'(cfg_q.throttle_min);
      RegThrottleMax:    prdata = ApbDataW'(cfg_q.throttle_max);
      RegInjectorOffset: prdata = ApbDataW'(cfg_q.injector_offset);
      RegCorrectionSpan: prdata = ApbDataW'(cfg_q.correction_span);
      RegStallLimit:     prdata = ApbDataW'(cfg_q.stall_limit);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.throttle_min    <= ThrottleMinRst;
      cfg_q.throttle_max    <= ThrottleMaxRst;
      cfg_q.injector_offset <= InjectorOffsetRst;
      cfg_q.correction_span <= CorrectionSpanRst;
      cfg_q.stall_limit     <= StallLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[rtl/core/fipt_fuel_mem.sv]
`timescale 1ns / 1ps
// Fuel time table: one write port, one registered read port, write-first on a collision.
// Depends on fipt_pkg for the entry width.
module fipt_fuel_mem
  import fipt_pkg::*;
#(
  parameter  int unsigned Depth = DefaultTableDepth,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic              clk_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [EntryW-1:0] wdata_i,
  output logic [EntryW-1:0] rdata_o
);

  logic [EntryW-1:0] mem [Depth];
  logic [EntryW-1:0] rdata_q;

  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // A read of the entry being written in the same cycle returns the new data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem[raddr_i];
      end
    end
  end

endmodule

[rtl/core/fuel_injector_pulse_timer.sv]
`timescale 1ns / 1ps
// Top level of the fuel injector pulse timer: event pipeline around the fuel table.
// Depends on fipt_pkg, fipt_in_if, fipt_out_if, fipt_cfg_regs and fipt_fuel_mem.
//
// Usage. Each input beat on item_in is one event: a timer tick, a crank pulse, a throttle
// sample, a correction sample or a write into the fuel table. Every accepted event yields
// exactly one result beat on result_out, in order, carrying the injector state after the
// event: open flag, late flow fault, captured crank period, time left, throttle index and
// the low speed flag. The APB port writes and reads the five tuning registers; write them
// only while no event is in flight.
// The block takes one event per cycle while result_out.ready stays high: stage one
// forms the throttle and correction products and issues the fuel table read, stage two
// scales the products and commits the state, and an output register holds the result.
// A crank pulse reads the table entry of the throttle index that is current for it; a
// throttle sample one stage ahead forwards its new index to the read address, and a table
// write committing in the same cycle is forwarded by the memory. When the receiver stalls,
// the output register holds its beat and the two stages behind it keep filling, so up to
// two more events are taken before item_in.ready drops. Reset clears all engine state and
// restores the register defaults; the fuel table itself is not cleared and each entry must
// be written before use.
module fuel_injector_pulse_timer
  import fipt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DefaultTableDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  fipt_in_if.sink             item_in,
  fipt_out_if.source          result_out,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned AddrW  = $clog2(TABLE_DEPTH);
  localparam int          MaxIdx = TABLE_DEPTH - 1;

  fipt_cfg_t cfg;

  // Handshake and stage occupancy.
  logic out_free, s2_free, s1_free, in_fire, commit, rd_en;
  logic s1_valid_q, s2_valid_q, out_valid_q;

  // Stage one payload.
  fipt_op_e          s1_op_q;
  logic [SampleW-1:0] s1_sample_q;
  logic [IndexW-1:0] s1_eidx_q;
  logic [EntryW-1:0] s1_eval_q;

  // Stage two payload.
  fipt_op_e           s2_op_q;
  logic [IndexW-1:0]  s2_eidx_q;
  logic [EntryW-1:0]  s2_eval_q;
  logic signed [15:0] s2_thr_prod_q;
  logic [15:0]        s2_corr_prod_q;

  // Engine state.
  logic [TimeW-1:0]  remaining_q, remaining_d;
  logic [TachW-1:0]  tach_q, tach_d;
  logic [TachW-1:0]  period_q, period_d;
  logic              debounce_q, debounce_d;
  logic [IndexW-1:0] index_q, index_d;
  logic [EntryW-1:0] corr_q, corr_d;
  logic              fault_d;

  // Result register.
  logic              res_open_q, res_fault_q, res_low_q;
  logic [TachW-1:0]  res_period_q;
  logic [TimeW-1:0]  res_time_q;
  logic [IndexW-1:0] res_index_q;

  // Stage one arithmetic.
  logic [SampleW-1:0] raw_m1;
  logic signed [7:0]  thr_span;
  logic signed [16:0] thr_prod;
  logic [15:0]        corr_prod;

  // Stage two arithmetic.
  logic               thr_neg;
  logic [15:0]        thr_mag;
  logic [14:0]        thr_half, thr_q_sum;
  logic [IndexW-1:0]  thr_qm;
  logic signed [8:0]  thr_idx_s;
  logic [IndexW-1:0]  thr_idx_new;
  logic [16:0]        corr_sum;
  logic [EntryW-1:0]  corr_new;
  logic [9:0]         pulse_sum;

  // Fuel table port.
  logic              mem_we;
  logic [IndexW-1:0] rd_index;
  logic [EntryW-1:0] base_fuel;

  fipt_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Each stage advances when the stage ahead of it is empty or moving on.
  assign out_free      = !out_valid_q || result_out.ready;
  assign s2_free       = !s2_valid_q || out_free;
  assign s1_free       = !s1_valid_q || s2_free;
  assign item_in.ready = s1_free;
  assign in_fire       = item_in.valid && s1_free;
  assign commit        = s2_valid_q && out_free;
  assign rd_en         = s1_valid_q && s2_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= item_in.valid;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_free) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q     <= fipt_op_e'(item_in.op);
      s1_sample_q <= item_in.sample;
      s1_eidx_q   <= item_in.entry_index;
      s1_eval_q   <= item_in.entry_value;
    end
  end

  // Stage one: throttle product (raw-1)*(max-min), with raw 0 read as 1, and the
  // correction product sample*span. Both are registered before scaling.
  always_comb begin
    raw_m1    = (s1_sample_q == '0) ? '0 : s1_sample_q - 8'd1;
    thr_span  = $signed({1'b0, cfg.throttle_max}) - $signed({1'b0, cfg.throttle_min});
    thr_prod  = 17'($signed({1'b0, raw_m1})) * 17'(thr_span);
    corr_prod = 16'(s1_sample_q) * 16'(cfg.correction_span);
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s2_op_q        <= s1_op_q;
      s2_eidx_q      <= s1_eidx_q;
      s2_eval_q      <= s1_eval_q;
      s2_thr_prod_q  <= thr_prod[15:0];
      s2_corr_prod_q <= corr_prod;
    end
  end

  // Stage two: divide the throttle product by 254, truncating toward zero. The
  // magnitude is halved and then divided by 127 with the 2^7-1 reciprocal identity,
  // exact below 2^14. The correction product is divided by 255 the same way.
  always_comb begin
    thr_neg   = s2_thr_prod_q[15];
    thr_mag   = thr_neg ? 16'(-s2_thr_prod_q) : 16'(s2_thr_prod_q);
    thr_half  = thr_mag[15:1];
    thr_q_sum = thr_half + 15'(thr_half >> 7) + 15'd1;
    thr_qm    = thr_q_sum[13:7];
    thr_idx_s = $signed({2'b00, cfg.throttle_min})
              + (thr_neg ? -$signed({2'b00, thr_qm}) : $signed({2'b00, thr_qm}));
    if (thr_idx_s < 0) begin
      thr_idx_new = '0;
    end else if (int'(thr_idx_s) > MaxIdx) begin
      thr_idx_new = IndexW'(MaxIdx);
    end else begin
      thr_idx_new = thr_idx_s[IndexW-1:0];
    end
    corr_sum = 17'(s2_corr_prod_q) + 17'(s2_corr_prod_q >> 8) + 17'd1;
    corr_new = corr_sum[15:8];
  end

  // The item in stage one reads the entry of the index that holds after the item
  // in stage two, which commits at the same edge.
  assign rd_index = (s2_valid_q && (s2_op_q == OpThrottle)) ? thr_idx_new : index_q;
  assign mem_we   = commit && (s2_op_q == OpTableWrite) && (32'(s2_eidx_q) < TABLE_DEPTH);

  fipt_fuel_mem #(
    .Depth (TABLE_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .re_i    (rd_en),
    .raddr_i (AddrW'(rd_index)),
    .we_i    (mem_we),
    .waddr_i (AddrW'(s2_eidx_q)),
    .wdata_i (s2_eval_q),
    .rdata_o (base_fuel)
  );

  assign pulse_sum = 10'(cfg.injector_offset) + 10'(base_fuel) + 10'(corr_q);

  always_comb begin
    remaining_d = remaining_q;
    tach_d      = tach_q;
    period_d    = period_q;
    debounce_d  = debounce_q;
    index_d     = index_q;
    corr_d      = corr_q;
    fault_d     = 1'b0;
    case (s2_op_q)
      OpTick: begin
        debounce_d = 1'b0;
        if (tach_q < cfg.stall_limit) begin
          tach_d = tach_q + 16'd1;
        end
        if (remaining_q != '0) begin
          remaining_d = remaining_q - 10'd1;
        end
      end
      OpCrank: begin
        period_d = tach_q;
        tach_d   = '0;
        if (!debounce_q) begin
          debounce_d  = 1'b1;
          fault_d     = (remaining_q != '0);
          remaining_d = pulse_sum;
        end
      end
      OpThrottle:   index_d = thr_idx_new;
      OpCorrection: corr_d  = corr_new;
      default:      ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remaining_q <= '0;
      tach_q      <= '0;
      period_q    <= '0;
      debounce_q  <= 1'b0;
      index_q     <= '0;
      corr_q      <= '0;
    end else if (commit) begin
      remaining_q <= remaining_d;
      tach_q      <= tach_d;
      period_q    <= period_d;
      debounce_q  <= debounce_d;
      index_q     <= index_d;
      corr_q      <= corr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      res_open_q   <= (remaining_d != '0);
      res_fault_q  <= fault_d;
      res_period_q <= period_d;
      res_time_q   <= remaining_d;
      res_index_q  <= index_d;
      res_low_q    <= (tach_d >= cfg.stall_limit);
    end
  end

  assign result_out.valid           = out_valid_q;
  assign result_out.injector_open   = res_open_q;
  assign result_out.late_flow_fault = res_fault_q;
  assign result_out.period_ticks    = res_period_q;
  assign result_out.time_left       = res_time_q;
  assign result_out.index_now       = res_index_q;
  assign result_out.low_speed       = res_low_q;

`ifndef SYNTHESIS
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q)
    else $error("accepted beat did not enter stage one");

  a_open_matches_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_open_q == (res_time_q != '0)))
    else $error("injector_open disagrees with time_left");

  a_tick_counts_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && (s2_op_q == OpTick) && (remaining_q != '0))
      |=> (remaining_q == $past(remaining_q) - 10'd1))
    else $error("tick did not decrement the remaining time");

  a_crank_debounce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && (s2_op_q == OpCrank)) |=> (debounce_q && (tach_q == '0)))
    else $error("crank pulse left debounce clear or tach count running");
`endif

endmodule

[sim/tb_fuel_injector_pulse_timer.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the fuel injector pulse timer: directed and random events
// checked beat by beat against a behavioral predictor, with APB register programming.
// Depends on fipt_pkg, fipt_in_if, fipt_out_if and the fuel_injector_pulse_timer RTL.
module tb_fuel_injector_pulse_timer;
  import fipt_pkg::*;

  // Op codes the block must accept and ignore.
  localparam logic [OpW-1:0] OpSpare5 = 3'd5;
  localparam logic [OpW-1:0] OpSpare6 = 3'd6;
  localparam logic [OpW-1:0] OpSpare7 = 3'd7;

  // Throttle map divisor and full-scale converter reading.
  localparam int ThrottleSteps = 254;
  localparam int SampleFull    = 255;

  localparam int unsigned PipeLatency   = 3;
  localparam int unsigned ItemsPerPhase = 115;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned RareIdlePct   = 9;
  localparam int unsigned BusyIdlePct   = 71;

  typedef enum int unsigned {
    StallMostlyReceiver = 0,
    StallMostlySender   = 1,
    StallNone           = 2
  } stall_mode_e;

  typedef struct packed {
    logic [OpW-1:0]     op;
    logic [SampleW-1:0] sample;
    logic [IndexW-1:0]  entry_index;
    logic [EntryW-1:0]  entry_value;
  } event_t;

  typedef struct packed {
    logic              injector_open;
    logic              late_flow_fault;
    logic [TachW-1:0]  period_ticks;
    logic [TimeW-1:0]  time_left;
    logic [IndexW-1:0] index_now;
    logic              low_speed;
  } status_t;

  // One directed event; when hand_checked is set, status is the beat it must produce.
  typedef struct packed {
    event_t  ev;
    logic    hand_checked;
    status_t status;
  } directed_row_t;

  localparam status_t AllClear = '0;

  logic clk_i;
  logic rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  fipt_in_if  event_bus ();
  fipt_out_if status_bus ();

  fuel_injector_pulse_timer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_in    (event_bus),
    .result_out (status_bus),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Predictor copy of the tuning registers.
  logic [IndexW-1:0] set_throttle_lo;
  logic [IndexW-1:0] set_throttle_hi;
  logic [EntryW-1:0] set_dead_time;
  logic [EntryW-1:0] set_corr_span;
  logic [TachW-1:0]  set_stall_limit;

  // Predictor copy of the engine state. The loaded flags track which fuel table entries
  // have been written, so that no crank pulse is ever sent that would read a blank one.
  logic [EntryW-1:0] fuel_map [DefaultTableDepth];
  bit                fuel_map_loaded [DefaultTableDepth];
  logic [TimeW-1:0]  time_left;
  logic [TachW-1:0]  tach_count;
  logic [TachW-1:0]  period;
  logic              debounce_set;
  logic [IndexW-1:0] throttle_idx;
  logic [EntryW-1:0] correction;

  status_t     pending_status [$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned tick_burst;
  stall_mode_e idle_mode;

  // Side information that travels with the beat on the input channel.
  logic    beat_hand_checked;
  status_t beat_status;

  // The directed walk starts from the reset settings: range 0..119, dead time 1,
  // correction span 30, stall limit 20000. It covers the unused op codes, both ends of
  // the table and of the sample range, a crank pulse held off by the debounce flag, a
  // crank pulse that finds the injector still open, and an injection that runs out.
  directed_row_t directed_rows [24] = '{
    '{'{OpTick,       8'd0,   7'd0,   8'd0  }, 1'b1, AllClear},
    '{'{OpSpare5,     8'hFF,  7'h7F,  8'hFF }, 1'b1, AllClear},
    '{'{OpSpare6,     8'd0,   7'd0,   8'd0  }, 1'b1, AllClear},
    '{'{OpSpare7,     8'h5A,  7'h2A,  8'hA5 }, 1'b1, AllClear},
    '{'{OpTableWrite, 8'd0,   7'd0,   8'd255}, 1'b1, AllClear},
    '{'{OpTableWrite, 8'd0,   7'd127, 8'd0  }, 1'b1, AllClear},
    '{'{OpThrottle,   8'd0,   7'd0,   8'd0  }, 1'b1, AllClear},
    '{'{OpCorrection, 8'd255, 7'd0,   8'd0  }, 1'b1, AllClear},
    '{'{OpCrank,      8'd0,   7'd0,   8'd0  }, 1'b1,
      '{1'b1, 1'b0, 16'd1, 10'd286, 7'd0, 1'b0}},
    '{'{OpCrank,      8'd0,   7'd0,   8'd0  }, 1'b1,
      '{1'b1, 1'b0, 16'd0, 10'd286, 7'd0, 1'b0}},
    '{'{OpTick,       8'd0,   7'd0,   8'd0  }, 1'b1,
      '{1'b1, 1'b0, 16'd0, 10'd285, 7'd0, 1'b0}},
    '{'{OpCrank,      8'd0,   7'd0,   8'd0  }, 1'b1,
      '{1'b1, 1'b1, 16'd1, 10'd286, 7'd0, 1'b0}},
    '{'{OpThrottle,   8'd255, 7'd0,   8'd0  }, 1'b1,
      '{1'b1, 1'b0, 16'd1, 10'd286, 7'd119, 1'b0}},
    '{'{OpTableWrite, 8'd0,   7'd119, 8'd0  }, 1'b1,
      '{1'b1, 1'b0, 16'd1, 10'd286, 7'd119, 1'b0}},
    '{'{OpCorrection, 8'd0,   7'd0,   8'd0  }, 1'b1,
      '{1'b1, 1'b0, 16'd1, 10'd286, 7'd119, 1'b0}},
    '{'{OpTick,       8'd0,   7'd0,   8'd0  }, 1'b1,
      '{1'b1, 1'b0, 16'd1, 10'd285, 7'd119, 1'b0}},
    '{'{OpCrank,      8'd0,   7'd0,   8'd0  }, 1'b1,
      '{1'b1, 1'b1, 16'd1, 10'd1, 7'd119, 1'b0}},
    '{'{OpTick,       8'd0,   7'd0,   8'd0  }, 1'b1,
      '{1'b0, 1'b0, 16'd1, 10'd0, 7'd119, 1'b0}},
    '{'{OpTick,       8'd0,   7'd0,   8'd0  }, 1'b1,
      '{1'b0, 1'b0, 16'd1, 10'd0, 7'd119, 1'b0}},
    '{'{OpCrank,      8'd0,   7'd0,   8'd0  }, 1'b1,
      '{1'b1, 1'b0, 16'd2, 10'd1, 7'd119, 1'b0}},
    '{'{OpThrottle,   8'd128, 7'd0,   8'd0  }, 1'b0, AllClear},
    '{'{OpThrottle,   8'd1,   7'd0,   8'd0  }, 1'b1,
      '{1'b1, 1'b0, 16'd2, 10'd1, 7'd0, 1'b0}},
    '{'{OpCorrection, 8'd128, 7'd0,   8'd0  }, 1'b0, AllClear},
    '{'{OpCrank,      8'd0,   7'd0,   8'd0  }, 1'b0, AllClear}
  };

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // A hung handshake or a lost beat ends the run here.
  initial begin : watchdog
    wait (cycle_count >= CycleLimit);
    $display("** fuel_injector_pulse_timer: FAILED **");
    $finish;
  end

  // Works out the status beat of one event and advances the predicted state.
  function automatic status_t predict_injector_status(input event_t ev);
    status_t st;
    int      raw;
    int      mapped;
    logic    fault;
    fault = 1'b0;
    case (ev.op)
      OpTick: begin
        debounce_set = 1'b0;
        if (tach_count < set_stall_limit) tach_count = tach_count + 16'd1;
        if (time_left != '0) time_left = time_left - 10'd1;
      end
      OpCrank: begin
        period     = tach_count;
        tach_count = '0;
        // Only the first pulse after a tick starts an injection; bounces are ignored.
        if (!debounce_set) begin
          debounce_set = 1'b1;
          fault        = (time_left != '0);
          time_left    = {2'b00, set_dead_time} + {2'b00, fuel_map[throttle_idx]}
                         + {2'b00, correction};
        end
      end
      OpThrottle: begin
        // Linear map with signed arithmetic so that a reversed range falls off cleanly.
        raw    = (ev.sample == '0) ? 1 : int'(ev.sample);
        mapped = int'(set_throttle_lo)
                 + ((raw - 1) * (int'(set_throttle_hi) - int'(set_throttle_lo)))
                 / ThrottleSteps;
        if (mapped < 0) mapped = 0;
        if (mapped > int'(DefaultTableDepth) - 1) mapped = int'(DefaultTableDepth) - 1;
        throttle_idx = IndexW'(mapped);
      end
      OpCorrection: begin
        correction = EntryW'((int'(ev.sample) * int'(set_corr_span)) / SampleFull);
      end
      OpTableWrite: begin
        fuel_map[ev.entry_index]        = ev.entry_value;
        fuel_map_loaded[ev.entry_index] = 1'b1;
      end
      default: begin
      end
    endcase
    st.injector_open   = (time_left != '0);
    st.late_flow_fault = fault;
    st.period_ticks    = period;
    st.time_left       = time_left;
    st.index_now       = throttle_idx;
    st.low_speed       = (tach_count >= set_stall_limit);
    return st;
  endfunction

  // Random event. Runs of ticks let injections drain and the tach counter saturate;
  // table writes often hit the current throttle index so that pulses read fresh data.
  function automatic event_t random_event();
    event_t      ev;
    int unsigned pick;
    ev.sample      = SampleW'($urandom);
    ev.entry_index = IndexW'($urandom);
    ev.entry_value = EntryW'($urandom);
    pick = $urandom_range(0, 99);
    if (tick_burst != 0) begin
      tick_burst--;
      pick = 0;
    end else if (pick < 6) begin
      tick_burst = $urandom_range(5, 60);
    end
    if (pick < 45) ev.op = OpTick;
    else if (pick < 60) ev.op = OpCrank;
    else if (pick < 70) ev.op = OpThrottle;
    else if (pick < 78) ev.op = OpCorrection;
    else if (pick < 95) ev.op = OpTableWrite;
    else begin
      case ($urandom_range(0, 2))
        0:       ev.op = OpSpare5;
        1:       ev.op = OpSpare6;
        default: ev.op = OpSpare7;
      endcase
    end
    if (ev.op == OpTableWrite) begin
      if ($urandom_range(0, 1) == 1) ev.entry_index = throttle_idx;
      if ($urandom_range(0, 1) == 1) ev.entry_value = EntryW'($urandom_range(0, 15));
    end
    // A pulse that would read a blank entry becomes the write that fills it.
    if (ev.op == OpCrank && !debounce_set && !fuel_map_loaded[throttle_idx]) begin
      ev.op          = OpTableWrite;
      ev.entry_index = throttle_idx;
    end
    return ev;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      error_count++;
    end
  endtask

  // Predicts every accepted input beat and checks every accepted status beat.
  always @(posedge clk_i) begin : beat_monitor
    status_t want;
    event_t  ev;
    if (rst_ni) begin
      if (event_bus.valid && event_bus.ready) begin
        ev   = '{event_bus.op, event_bus.sample, event_bus.entry_index, event_bus.entry_value};
        want = predict_injector_status(ev);
        if (beat_hand_checked) want = beat_status;
        pending_status.push_back(want);
      end
      if (status_bus.valid && status_bus.ready) begin
        if (pending_status.size() == 0) begin
          $error("status beat with no event waiting for it");
          error_count++;
        end else begin
          want = pending_status.pop_front();
          compare_field("injector_open", 32'(want.injector_open),
                        32'(status_bus.injector_open));
          compare_field("late_flow_fault", 32'(want.late_flow_fault),
                        32'(status_bus.late_flow_fault));
          compare_field("period_ticks", 32'(want.period_ticks),
                        32'(status_bus.period_ticks));
          compare_field("time_left", 32'(want.time_left), 32'(status_bus.time_left));
          compare_field("index_now", 32'(want.index_now), 32'(status_bus.index_now));
          compare_field("low_speed", 32'(want.low_speed), 32'(status_bus.low_speed));
        end
      end
    end
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk_i) begin
    case (idle_mode)
      StallMostlyReceiver: status_bus.ready <= ($urandom_range(0, 99) >= BusyIdlePct);
      StallMostlySender:   status_bus.ready <= ($urandom_range(0, 99) >= RareIdlePct);
      default:             status_bus.ready <= 1'b1;
    endcase
  end

  // Presents one event at a falling edge, after random idle cycles, and returns at the
  // falling edge after the rising edge that took it. Valid stays high on return so
  // that back-to-back beats leave no gap.
  task automatic send_event(input event_t ev, input logic hand_checked,
                            input status_t status);
    int unsigned idle_pct;
    case (idle_mode)
      StallMostlyReceiver: idle_pct = RareIdlePct;
      StallMostlySender:   idle_pct = BusyIdlePct;
      default:             idle_pct = 0;
    endcase
    while ($urandom_range(0, 99) < idle_pct) begin
      event_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    event_bus.valid       <= 1'b1;
    event_bus.op          <= ev.op;
    event_bus.sample      <= ev.sample;
    event_bus.entry_index <= ev.entry_index;
    event_bus.entry_value <= ev.entry_value;
    beat_hand_checked     <= hand_checked;
    beat_status           <= status;
    do @(posedge clk_i); while (!event_bus.ready);
    @(negedge clk_i);
  endtask

  // Stops the input and waits until every status beat is back and the pipe is empty.
  task automatic settle_pipeline();
    event_bus.valid <= 1'b0;
    while (pending_status.size() != 0) @(negedge clk_i);
    repeat (PipeLatency + 1) @(negedge clk_i);
  endtask

  // One APB transfer: setup phase, then access phase until pready. The read data is
  // taken at the completing rising edge. The bus returns to idle after every transfer.
  task automatic apb_access(input logic write, input fipt_reg_e which,
                            input logic [ApbDataW-1:0] wdata,
                            output logic [ApbDataW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {which, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic expect_reg(input fipt_reg_e which, input logic [ApbDataW-1:0] value);
    logic [ApbDataW-1:0] got;
    apb_access(1'b0, which, '0, got);
    if (got !== value) begin
      $error("register %s: expected %0d, actual %0d", which.name(), value, got);
      error_count++;
    end
  endtask

  // Writes a register, mirrors it into the predictor and reads it back.
  task automatic program_reg(input fipt_reg_e which, input logic [ApbDataW-1:0] value);
    logic [ApbDataW-1:0] ignored_rdata;
    apb_access(1'b1, which, value, ignored_rdata);
    case (which)
      RegThrottleMin:    set_throttle_lo = value[IndexW-1:0];
      RegThrottleMax:    set_throttle_hi = value[IndexW-1:0];
      RegInjectorOffset: set_dead_time   = value[EntryW-1:0];
      RegCorrectionSpan: set_corr_span   = value[EntryW-1:0];
      RegStallLimit:     set_stall_limit = value[TachW-1:0];
      default: begin
      end
    endcase
    expect_reg(which, value);
  endtask

  initial begin : stimulus
    int unsigned       phase;
    logic [IndexW-1:0] lo;
    logic [IndexW-1:0] hi;
    logic [EntryW-1:0] dead;
    logic [EntryW-1:0] span;
    logic [TachW-1:0]  stall;

    // Every input known from time zero, reset asserted.
    rst_ni                = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    event_bus.valid       = 1'b0;
    event_bus.op          = '0;
    event_bus.sample      = '0;
    event_bus.entry_index = '0;
    event_bus.entry_value = '0;
    status_bus.ready      = 1'b0;
    beat_hand_checked     = 1'b0;
    beat_status           = AllClear;
    error_count           = 0;
    cycle_count           = 0;
    tick_burst            = 0;
    idle_mode             = StallMostlyReceiver;

    set_throttle_lo = ThrottleMinRst;
    set_throttle_hi = ThrottleMaxRst;
    set_dead_time   = InjectorOffsetRst;
    set_corr_span   = CorrectionSpanRst;
    set_stall_limit = StallLimitRst;
    for (int i = 0; i < DefaultTableDepth; i++) begin
      fuel_map[i]        = '0;
      fuel_map_loaded[i] = 1'b0;
    end
    time_left    = '0;
    tach_count   = '0;
    period       = '0;
    debounce_set = 1'b0;
    throttle_idx = '0;
    correction   = '0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // The registers must come out of reset at their defaults.
    expect_reg(RegThrottleMin, ApbDataW'(ThrottleMinRst));
    expect_reg(RegThrottleMax, ApbDataW'(ThrottleMaxRst));
    expect_reg(RegInjectorOffset, ApbDataW'(InjectorOffsetRst));
    expect_reg(RegCorrectionSpan, ApbDataW'(CorrectionSpanRst));
    expect_reg(RegStallLimit, ApbDataW'(StallLimitRst));

    foreach (directed_rows[i])
      send_event(directed_rows[i].ev, directed_rows[i].hand_checked,
                 directed_rows[i].status);

    // Random phases. Two per idling pattern: heavy receiver stalls, then heavy sender
    // gaps, then full rate. The first phases take the register extremes, including a
    // reversed throttle range; later ones use random settings, one of them a zero stall limit.
    for (phase = 0; phase < 6; phase++) begin
      settle_pipeline();
      idle_mode = stall_mode_e'(phase / 2);
      lo    = IndexW'($urandom);
      hi    = IndexW'($urandom);
      dead  = EntryW'($urandom);
      span  = EntryW'($urandom);
      stall = TachW'($urandom_range(1, 300));
      case (phase)
        0: begin
          lo    = '0;
          hi    = '1;
          dead  = '1;
          span  = '1;
          stall = '1;
        end
        1: begin
          lo    = '1;
          hi    = '0;
          dead  = '0;
          span  = '0;
          stall = 16'd1;
        end
        2: stall = TachW'($urandom_range(2, 40));
        3: begin
          hi    = lo;
          stall = '0;
        end
        4: dead = EntryW'($urandom_range(0, 8));
        default: stall = TachW'($urandom_range(1, 65535));
      endcase
      program_reg(RegThrottleMin, ApbDataW'(lo));
      program_reg(RegThrottleMax, ApbDataW'(hi));
      program_reg(RegInjectorOffset, ApbDataW'(dead));
      program_reg(RegCorrectionSpan, ApbDataW'(span));
      program_reg(RegStallLimit, ApbDataW'(stall));
      repeat (ItemsPerPhase) send_event(random_event(), 1'b0, AllClear);
    end

    settle_pipeline();
    repeat (2 * PipeLatency) @(negedge clk_i);
    if (error_count == 0 && pending_status.size() == 0) begin
      $display("** fuel_injector_pulse_timer: PASSED **");
    end else begin
      $display("** fuel_injector_pulse_timer: FAILED **");
    end
    $finish;
  end

endmodule
